// ===== sv/ibpm_pkg.sv =====
// Shared types, codes and the button mask table of the input binding pad mapper.
package ibpm_pkg;

    localparam int BUTTONS_PER_SLOT = 8;
    localparam int VALUE_W          = 16;
    localparam int TYPE_W           = 3;

    // Operation codes.
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_BIND  = 1'b1;

    // Event kinds.
    localparam logic [3:0] KIND_KEY_DOWN   = 4'd0;
    localparam logic [3:0] KIND_KEY_UP     = 4'd1;
    localparam logic [3:0] KIND_AXIS       = 4'd2;
    localparam logic [3:0] KIND_HAT        = 4'd3;
    localparam logic [3:0] KIND_BTN_DOWN   = 4'd4;
    localparam logic [3:0] KIND_BTN_UP     = 4'd5;
    localparam logic [3:0] KIND_MOUSE_DOWN = 4'd6;
    localparam logic [3:0] KIND_MOUSE_UP   = 4'd7;

    // Binding entry types.
    localparam logic [TYPE_W-1:0] TYPE_UNUSED = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_KEY    = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_AXIS   = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_HAT    = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_JBTN   = 3'd4;

    localparam logic [7:0] MOUSE_LEFT_MASK  = 8'h02;
    localparam logic [7:0] MOUSE_OTHER_MASK = 8'h01;
    localparam logic [7:0] AXIS_NEG_BYTE    = 8'hFF;

    typedef struct packed {
        logic              operation;
        logic [3:0]        event_kind;
        logic [8:0]        event_code;
        logic              axis_negative;
        logic [3:0]        hat_position;
        logic              mouse_is_left;
        logic [1:0]        bind_slot;
        logic [2:0]        bind_button;
        logic [TYPE_W-1:0] bind_type;
        logic [VALUE_W-1:0] bind_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] pad_one_bits;
        logic [7:0] pad_two_bits;
    } t_out_word;

    typedef struct packed {
        logic [TYPE_W-1:0]  etype;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic [TYPE_W-1:0]  ktype;
        logic [VALUE_W-1:0] value;
        logic               down;
    } t_key;

    typedef struct packed {
        logic hit;
        logic on;
    } t_hit;

    // Pad bit driven by each button position of a slot.
    function automatic logic [7:0] pad_mask(input logic [2:0] btn);
        logic [7:0] m;
        unique case (btn)
            3'd0: m = 8'h10;
            3'd1: m = 8'h20;
            3'd2: m = 8'h40;
            3'd3: m = 8'h80;
            3'd4: m = 8'h01;
            3'd5: m = 8'h02;
            3'd6: m = 8'h04;
            3'd7: m = 8'h08;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/ibpm_table.sv =====
// Binding table memory with per-entry valid bits and a registered read port.
module ibpm_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  ibpm_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output ibpm_pkg::t_entry  o_rdata
);

    ibpm_pkg::t_entry r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    ibpm_pkg::t_entry r_rd;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    // An entry never written reads as unused with value zero.
    assign o_rdata = r_rd_vld ? r_rd : '0;

endmodule

// ===== sv/ibpm_match.sv =====
// Compare unit shared by every table entry during a scan.
module ibpm_match (
    input  ibpm_pkg::t_entry i_entry,
    input  ibpm_pkg::t_key   i_key,
    output ibpm_pkg::t_hit   o_hit
);

    logic exact;
    logic full_eq;
    logic high_eq;

    assign exact   = (i_key.ktype == ibpm_pkg::TYPE_KEY) || (i_key.ktype == ibpm_pkg::TYPE_JBTN);
    assign full_eq = (i_entry.value == i_key.value);
    assign high_eq = (i_entry.value[15:8] == i_key.value[15:8]);

    always_comb begin
        o_hit.hit = (i_entry.etype == i_key.ktype) && (exact ? full_eq : high_eq);
        o_hit.on  = exact ? i_key.down : full_eq;
    end

endmodule

// ===== sv/input_binding_pad_mapper.sv =====
// Top level of the input binding pad mapper: sequencer, pad state and output register.
//
//  channel  direction  valid        stall        word
//  input    in         i_in_valid   o_in_stall   i_in_word  (ibpm_pkg::t_in_word)
//  output   out        o_out_valid  i_out_stall  o_out_word (ibpm_pkg::t_out_word)
//
// A bind, mouse or ignored word goes to the done state, which loads the output register.
// A key, axis, hat or joystick-button word scans the table one entry a cycle through
// the single memory read port and compare unit, then goes to the done state.
// The input opens again in the cycle after the output register is loaded.
// Reset clears the table valid bits and both pads directly; no clearing pass.
// A stalled output holds the next result back; the input stays stalled until it is loaded.
module input_binding_pad_mapper #(
    parameter int NUM_SLOTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ibpm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ibpm_pkg::t_out_word o_out_word
);

    localparam int DEPTH = NUM_SLOTS * ibpm_pkg::BUTTONS_PER_SLOT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state;
    logic [7:0]          r_pad1;
    logic [7:0]          r_pad2;
    ibpm_pkg::t_key      r_key;
    logic [AW-1:0]       r_rd_addr;
    logic                r_issue;
    logic [AW-1:0]       r_cmp_addr;
    logic                r_cmp_go;
    logic                r_out_valid;
    ibpm_pkg::t_out_word r_out_word;

    logic                in_acc;
    logic                bind_we;
    logic [AW-1:0]       bind_addr;
    ibpm_pkg::t_entry    bind_data;
    ibpm_pkg::t_entry    rd_entry;
    ibpm_pkg::t_hit      hit;
    ibpm_pkg::t_key      n_key;
    logic                start_scan;
    logic [7:0]          mouse_mask;
    logic [7:0]          cmp_mask;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign bind_we   = in_acc && (i_in_word.operation == ibpm_pkg::OP_BIND)
                       && (int'(i_in_word.bind_slot) < NUM_SLOTS);
    assign bind_addr = AW'({i_in_word.bind_slot, i_in_word.bind_button});
    assign bind_data = '{etype: i_in_word.bind_type, value: i_in_word.bind_value};

    ibpm_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (bind_we),
        .i_waddr (bind_addr),
        .i_wdata (bind_data),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_entry)
    );

    ibpm_match u_match (
        .i_entry (rd_entry),
        .i_key   (r_key),
        .o_hit   (hit)
    );

    // Search key built from the event word.
    always_comb begin
        n_key      = '0;
        start_scan = 1'b0;
        unique case (i_in_word.event_kind)
            ibpm_pkg::KIND_KEY_DOWN, ibpm_pkg::KIND_KEY_UP: begin
                n_key.ktype = ibpm_pkg::TYPE_KEY;
                n_key.value = {7'd0, i_in_word.event_code};
                n_key.down  = (i_in_word.event_kind == ibpm_pkg::KIND_KEY_DOWN);
                start_scan  = 1'b1;
            end
            ibpm_pkg::KIND_AXIS: begin
                n_key.ktype = ibpm_pkg::TYPE_AXIS;
                n_key.value = {i_in_word.event_code[7:0],
                               i_in_word.axis_negative ? ibpm_pkg::AXIS_NEG_BYTE : 8'h00};
                start_scan  = 1'b1;
            end
            ibpm_pkg::KIND_HAT: begin
                n_key.ktype = ibpm_pkg::TYPE_HAT;
                n_key.value = {i_in_word.event_code[7:0], 4'd0, i_in_word.hat_position};
                start_scan  = 1'b1;
            end
            ibpm_pkg::KIND_BTN_DOWN, ibpm_pkg::KIND_BTN_UP: begin
                n_key.ktype = ibpm_pkg::TYPE_JBTN;
                n_key.value = {8'd0, i_in_word.event_code[7:0]};
                n_key.down  = (i_in_word.event_kind == ibpm_pkg::KIND_BTN_DOWN);
                start_scan  = 1'b1;
            end
            default: begin
                start_scan = 1'b0;
            end
        endcase
    end

    assign mouse_mask = i_in_word.mouse_is_left ? ibpm_pkg::MOUSE_LEFT_MASK
                                                : ibpm_pkg::MOUSE_OTHER_MASK;
    assign cmp_mask   = ibpm_pkg::pad_mask(r_cmp_addr[2:0]);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key <= n_key;
        end
        r_cmp_addr <= r_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pad1      <= '0;
            r_pad2      <= '0;
            r_rd_addr   <= '0;
            r_issue     <= 1'b0;
            r_cmp_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_word  <= '0;
        end else begin
            if (r_state == ST_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_go <= (r_state == ST_SCAN) && r_issue;

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in_word.operation == ibpm_pkg::OP_EVENT && start_scan) begin
                            r_state   <= ST_SCAN;
                            r_rd_addr <= '0;
                            r_issue   <= 1'b1;
                        end else begin
                            r_state <= ST_DONE;
                            if (i_in_word.operation == ibpm_pkg::OP_EVENT) begin
                                if (i_in_word.event_kind == ibpm_pkg::KIND_MOUSE_DOWN) begin
                                    r_pad1 <= r_pad1 | mouse_mask;
                                end else if (i_in_word.event_kind ==
                                             ibpm_pkg::KIND_MOUSE_UP) begin
                                    r_pad1 <= r_pad1 & ~mouse_mask;
                                end
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_issue) begin
                        if (r_rd_addr == AW'(DEPTH - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_addr <= r_rd_addr + 1'b1;
                        end
                    end
                    if (r_cmp_go) begin
                        // Address bit 3 is the low bit of the slot: odd slots drive pad two.
                        if (hit.hit) begin
                            if (!r_cmp_addr[3]) begin
                                r_pad1 <= hit.on ? (r_pad1 | cmp_mask) : (r_pad1 & ~cmp_mask);
                            end else begin
                                r_pad2 <= hit.on ? (r_pad2 | cmp_mask) : (r_pad2 & ~cmp_mask);
                            end
                        end
                        if (r_cmp_addr == AW'(DEPTH - 1)) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_word <= '{pad_one_bits: r_pad1, pad_two_bits: r_pad2};
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/ibpm_checker.sv =====
// Port-level checks of the input binding pad mapper and their binding to the top level.
module ibpm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input ibpm_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ibpm_pkg::t_out_word o_out_word
);

    // A result waiting on a stalled receiver holds its word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // Every accepted word keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted word");

    // Reset leaves no result pending and the input open.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the handshakes");

    // A new result is only produced while an item is in progress.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a word in progress");

endmodule

bind input_binding_pad_mapper ibpm_checker u_ibpm_checker (.*);

// ===== test/input_binding_pad_mapper_tb.sv =====
// Testbench of the input binding pad mapper: directed and random words against a table model.
module input_binding_pad_mapper_tb;

    localparam int SLOTS       = 4;
    localparam int BUTTONS     = ibpm_pkg::BUTTONS_PER_SLOT;
    localparam int TW          = ibpm_pkg::TYPE_W;
    localparam int VW          = ibpm_pkg::VALUE_W;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SCAN_CYCLES = SLOTS * BUTTONS + 8;
    localparam int IDLE_PCT    = 19;

    localparam logic [3:0]    KIND_IGNORED_FIRST = 4'd8;
    localparam logic [3:0]    KIND_IGNORED_LAST  = 4'd15;
    localparam logic [TW-1:0] TYPE_SPARE_FIRST   = 3'd5;
    localparam logic [TW-1:0] TYPE_SPARE_LAST    = 3'd7;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    ibpm_pkg::t_in_word  in_word   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ibpm_pkg::t_out_word out_word;

    logic [TW-1:0]       map_type  [SLOTS][BUTTONS];
    logic [VW-1:0]       map_value [SLOTS][BUTTONS];
    logic [7:0]          pad_one   = 8'h00;
    logic [7:0]          pad_two   = 8'h00;
    ibpm_pkg::t_out_word pads_due_q[$];
    int                  fail_count  = 0;
    int                  cycle_count = 0;
    bit                  idle_on     = 1'b1;

    input_binding_pad_mapper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] button_bit(input int btn);
        // Buttons 0 to 3 are the directions in the high nibble, 4 to 7 the low nibble.
        return (btn < 4) ? (8'h10 << btn) : (8'h01 << (btn - 4));
    endfunction

    // Applies one word to the table and pad model and returns the pads that must follow.
    function automatic ibpm_pkg::t_out_word update_pads(input ibpm_pkg::t_in_word w);
        logic [TW-1:0]       want;
        logic [VW-1:0]       probe;
        logic [VW-1:0]       held;
        logic                down;
        logic                hit;
        logic                on;
        logic [7:0]          m;
        logic [7:0]          mm;
        ibpm_pkg::t_out_word r;
        want  = ibpm_pkg::TYPE_UNUSED;
        probe = '0;
        down  = 1'b0;
        mm    = w.mouse_is_left ? ibpm_pkg::MOUSE_LEFT_MASK : ibpm_pkg::MOUSE_OTHER_MASK;
        if (w.operation == ibpm_pkg::OP_BIND) begin
            if (w.bind_slot < SLOTS) begin
                map_type[w.bind_slot][w.bind_button]  = w.bind_type;
                map_value[w.bind_slot][w.bind_button] = w.bind_value;
            end
        end else begin
            case (w.event_kind)
                ibpm_pkg::KIND_KEY_DOWN, ibpm_pkg::KIND_KEY_UP: begin
                    want  = ibpm_pkg::TYPE_KEY;
                    probe = {7'd0, w.event_code};
                    down  = (w.event_kind == ibpm_pkg::KIND_KEY_DOWN);
                end
                ibpm_pkg::KIND_AXIS: begin
                    want  = ibpm_pkg::TYPE_AXIS;
                    probe = {w.event_code[7:0],
                             w.axis_negative ? ibpm_pkg::AXIS_NEG_BYTE : 8'h00};
                end
                ibpm_pkg::KIND_HAT: begin
                    want  = ibpm_pkg::TYPE_HAT;
                    probe = {w.event_code[7:0], 4'h0, w.hat_position};
                end
                ibpm_pkg::KIND_BTN_DOWN, ibpm_pkg::KIND_BTN_UP: begin
                    want  = ibpm_pkg::TYPE_JBTN;
                    probe = {8'h00, w.event_code[7:0]};
                    down  = (w.event_kind == ibpm_pkg::KIND_BTN_DOWN);
                end
                ibpm_pkg::KIND_MOUSE_DOWN:
                    pad_one = pad_one | mm;
                ibpm_pkg::KIND_MOUSE_UP:
                    pad_one = pad_one & ~mm;
                default: ;
            endcase
            // Words that scan nothing leave want unused, and unused entries never match.
            if (want != ibpm_pkg::TYPE_UNUSED) begin
                for (int s = 0; s < SLOTS; s++) begin
                    for (int b = 0; b < BUTTONS; b++) begin
                        held = map_value[s][b];
                        if (map_type[s][b] == want) begin
                            if (want == ibpm_pkg::TYPE_KEY || want == ibpm_pkg::TYPE_JBTN) begin
                                hit = (held == probe);
                                on  = down;
                            end else begin
                                hit = (held[15:8] == probe[15:8]);
                                on  = (held == probe);
                            end
                            if (hit) begin
                                m = button_bit(b);
                                if (s % 2 == 0)
                                    pad_one = on ? (pad_one | m) : (pad_one & ~m);
                                else
                                    pad_two = on ? (pad_two | m) : (pad_two & ~m);
                            end
                        end
                    end
                end
            end
        end
        r.pad_one_bits = pad_one;
        r.pad_two_bits = pad_two;
        return r;
    endfunction

    function automatic ibpm_pkg::t_in_word noise_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(ibpm_pkg::t_in_word)-1:0];
    endfunction

    function automatic logic [8:0] pick_code();
        logic [8:0] c;
        // Mostly a handful of codes, so that events find their bindings.
        if ($urandom_range(0, 4) == 0)
            return 9'($urandom_range(0, 511));
        c    = 9'($urandom_range(0, 5));
        c[8] = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic ibpm_pkg::t_in_word make_bind(input logic [1:0] slot,
                                                     input logic [2:0] btn,
                                                     input logic [TW-1:0] etype,
                                                     input logic [VW-1:0] value);
        ibpm_pkg::t_in_word w;
        w             = noise_word();
        w.operation   = ibpm_pkg::OP_BIND;
        w.bind_slot   = slot;
        w.bind_button = btn;
        w.bind_type   = etype;
        w.bind_value  = value;
        return w;
    endfunction

    function automatic ibpm_pkg::t_in_word make_event(input logic [3:0] kind,
                                                      input logic [8:0] code,
                                                      input logic neg, input logic [3:0] hat,
                                                      input logic left);
        ibpm_pkg::t_in_word w;
        w               = noise_word();
        w.operation     = ibpm_pkg::OP_EVENT;
        w.event_kind    = kind;
        w.event_code    = code;
        w.axis_negative = neg;
        w.hat_position  = hat;
        w.mouse_is_left = left;
        return w;
    endfunction

    function automatic ibpm_pkg::t_in_word random_word();
        ibpm_pkg::t_in_word w;
        logic [8:0]         code;
        int                 roll;
        w    = noise_word();
        code = pick_code();
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return w;
        if (roll < 25) begin
            w.operation = ibpm_pkg::OP_BIND;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                w.bind_type = ibpm_pkg::TYPE_UNUSED;
            else if (roll < 16)
                w.bind_type = TW'($urandom_range(TYPE_SPARE_FIRST, TYPE_SPARE_LAST));
            else
                w.bind_type = TW'($urandom_range(ibpm_pkg::TYPE_KEY, ibpm_pkg::TYPE_JBTN));
            // A tenth of the binds, and every bind of an unused or spare type, keep a fully random value.
            if ($urandom_range(0, 9) != 0) begin
                case (w.bind_type)
                    ibpm_pkg::TYPE_KEY:  w.bind_value = {7'd0, code};
                    ibpm_pkg::TYPE_AXIS: w.bind_value = {code[7:0],
                        $urandom_range(0, 1) ? ibpm_pkg::AXIS_NEG_BYTE : 8'h00};
                    ibpm_pkg::TYPE_HAT:  w.bind_value = {code[7:0], 4'h0, w.hat_position};
                    ibpm_pkg::TYPE_JBTN: w.bind_value = {8'h00, code[7:0]};
                    default: ;
                endcase
            end
            return w;
        end
        w.operation  = ibpm_pkg::OP_EVENT;
        w.event_code = code;
        roll = $urandom_range(0, 99);
        if (roll < 15)      w.event_kind = ibpm_pkg::KIND_KEY_DOWN;
        else if (roll < 28) w.event_kind = ibpm_pkg::KIND_KEY_UP;
        else if (roll < 45) w.event_kind = ibpm_pkg::KIND_AXIS;
        else if (roll < 60) w.event_kind = ibpm_pkg::KIND_HAT;
        else if (roll < 72) w.event_kind = ibpm_pkg::KIND_BTN_DOWN;
        else if (roll < 82) w.event_kind = ibpm_pkg::KIND_BTN_UP;
        else if (roll < 90) w.event_kind = ibpm_pkg::KIND_MOUSE_DOWN;
        else if (roll < 97) w.event_kind = ibpm_pkg::KIND_MOUSE_UP;
        else w.event_kind = 4'($urandom_range(KIND_IGNORED_FIRST, KIND_IGNORED_LAST));
        return w;
    endfunction

    // Valid is left high after a word is taken; a gap or the next word replaces it.
    task automatic send_word(input ibpm_pkg::t_in_word w);
        ibpm_pkg::t_out_word due;
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while (idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        due        = update_pads(w);
        pads_due_q = {pads_due_q, due};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pads_due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_after_reset();
        send_word(make_event(ibpm_pkg::KIND_KEY_DOWN, 9'd0, 1'b0, 4'h0, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_AXIS, 9'd0, 1'b0, 4'h0, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_HAT, 9'd0, 1'b0, 4'h0, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_BTN_DOWN, 9'd0, 1'b0, 4'h0, 1'b0));
    endtask

    task automatic test_key_bindings();
        send_word(make_bind(2'd0, 3'd0, ibpm_pkg::TYPE_KEY, 16'h01FF));
        send_word(make_bind(2'd3, 3'd7, ibpm_pkg::TYPE_KEY, 16'h0000));
        send_word(make_event(ibpm_pkg::KIND_KEY_DOWN, 9'h1FF, 1'b0, 4'h0, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_KEY_DOWN, 9'h000, 1'b1, 4'hF, 1'b1));
        send_word(make_event(ibpm_pkg::KIND_KEY_UP, 9'h1FF, 1'b1, 4'hF, 1'b1));
    endtask

    task automatic test_axis_hat_bindings();
        send_word(make_bind(2'd1, 3'd2, ibpm_pkg::TYPE_AXIS, 16'hFFFF));
        send_word(make_bind(2'd1, 3'd3, ibpm_pkg::TYPE_AXIS, 16'hFF00));
        send_word(make_event(ibpm_pkg::KIND_AXIS, 9'h1FF, 1'b1, 4'h0, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_AXIS, 9'h0FF, 1'b0, 4'hF, 1'b1));
        send_word(make_bind(2'd2, 3'd2, ibpm_pkg::TYPE_HAT, 16'h0504));
        send_word(make_event(ibpm_pkg::KIND_HAT, 9'h005, 1'b0, 4'h4, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_HAT, 9'h105, 1'b1, 4'h8, 1'b1));
    endtask

    task automatic test_buttons_and_mouse();
        send_word(make_bind(2'd0, 3'd4, ibpm_pkg::TYPE_JBTN, 16'h00FF));
        send_word(make_event(ibpm_pkg::KIND_BTN_DOWN, 9'h1FF, 1'b0, 4'h0, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_BTN_UP, 9'h0FF, 1'b1, 4'hF, 1'b1));
        send_word(make_event(ibpm_pkg::KIND_MOUSE_DOWN, 9'h000, 1'b0, 4'h0, 1'b1));
        send_word(make_event(ibpm_pkg::KIND_MOUSE_DOWN, 9'h1FF, 1'b1, 4'hF, 1'b0));
        send_word(make_event(ibpm_pkg::KIND_MOUSE_UP, 9'h000, 1'b0, 4'h0, 1'b1));
    endtask

    task automatic test_ignored_and_spare_types();
        send_word(make_bind(2'd0, 3'd6, TYPE_SPARE_LAST, 16'h0001));
        send_word(make_event(ibpm_pkg::KIND_KEY_DOWN, 9'h001, 1'b0, 4'h0, 1'b0));
        send_word(make_event(KIND_IGNORED_LAST, 9'h1FF, 1'b1, 4'hF, 1'b1));
    endtask

    task automatic test_last_match_wins();
        // Both entries drive pad one B; the later slot decides the bit.
        send_word(make_bind(2'd0, 3'd5, ibpm_pkg::TYPE_AXIS, 16'h10FF));
        send_word(make_bind(2'd2, 3'd5, ibpm_pkg::TYPE_AXIS, 16'h1000));
        send_word(make_event(ibpm_pkg::KIND_AXIS, 9'h010, 1'b1, 4'h0, 1'b0));
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 1; n <= count; n++) begin
            send_word(random_word());
            if (n % 120 == 0)
                wait_drained();
        end
    endtask

    task automatic test_back_to_back(input int count);
        wait_drained();
        idle_on = 1'b0;
        for (int n = 0; n < count; n++)
            send_word(random_word());
        wait_drained();
        idle_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        ibpm_pkg::t_out_word due;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pads_due_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %04h", $time, out_word);
                fail_count++;
            end else begin
                due = pads_due_q.pop_front();
                if (out_word.pad_one_bits !== due.pad_one_bits) begin
                    $display("%0t: pad one expected %02h actual %02h",
                             $time, due.pad_one_bits, out_word.pad_one_bits);
                    fail_count++;
                end
                if (out_word.pad_two_bits !== due.pad_two_bits) begin
                    $display("%0t: pad two expected %02h actual %02h",
                             $time, due.pad_two_bits, out_word.pad_two_bits);
                    fail_count++;
                end
            end
        end
        out_stall <= i_rst_n && idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            for (int b = 0; b < BUTTONS; b++) begin
                map_type[s][b]  = ibpm_pkg::TYPE_UNUSED;
                map_value[s][b] = '0;
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_key_bindings();
        test_axis_hat_bindings();
        test_buttons_and_mouse();
        test_ignored_and_spare_types();
        test_last_match_wins();
        test_random_traffic(550);
        test_back_to_back(150);

        wait_drained();
        repeat (SCAN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
